// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files, used by the top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// ----- rtl/gdsa_pkg.sv -----
// constants and types of the goal distance and speed average block
`default_nettype none

package gdsa_pkg;

  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SLOT_W     = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W      = DATA_W + SLOT_W;
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned SREM_W     = DATA_W + 2;
  localparam int unsigned STEP_W     = $clog2(DATA_W);
  localparam int unsigned CFG_IDX_W  = 2;
  // width of the window field inside the register write data
  localparam int unsigned CFG_LEN_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd2;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

`default_nettype wire

// ----- rtl/gdsa_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module gdsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/goal_distance_and_speed_average_top.sv -----
// goal distance and moving speed average: sequencer, serial datapath and history ring
//
// Input channel: in_valid_i with in_stall_o; an item carries a position and two
// velocity samples, all signed Q16.16. Output channel: out_valid_o with out_stall_i;
// each input transfer gives exactly one result (distance to goal, two averages).
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; index 0
// and 1 set the goal, index 2 sets the window length from cfg_data_i[6:0] (0 acts as 1,
// above 64 acts as 64) and clears the history. Write configuration only while no item
// is in flight. From input transfer to out_valid_o come the ring read, the squares
// formed one multiplier bit per cycle, the square sum, the root one result bit per
// cycle and the output load. The two averages divide one quotient bit per cycle
// alongside the squares and the root.
// in_stall_o is high from an input transfer until its result is in the output
// register, so no new item is taken while one is in flight; the next item is accepted
// while the previous result still waits in the output register.
// If the receiver stalls, the finished result holds in the output register and a
// following item waits after its root until that register frees.
// Reset: goal 0, window length 1, empty history, both channels idle.
`default_nettype none

`include "assert_macros.svh"

module goal_distance_and_speed_average_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [gdsa_pkg::DATA_W-1:0]  pos_x_i,
  input  wire logic signed [gdsa_pkg::DATA_W-1:0]  pos_y_i,
  input  wire logic signed [gdsa_pkg::DATA_W-1:0]  lin_vel_i,
  input  wire logic signed [gdsa_pkg::DATA_W-1:0]  ang_vel_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic        [gdsa_pkg::DATA_W-1:0]       goal_dist_o,
  output logic signed [gdsa_pkg::DATA_W-1:0]       lin_avg_o,
  output logic signed [gdsa_pkg::DATA_W-1:0]       ang_avg_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic   [gdsa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic   [gdsa_pkg::DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned DW = gdsa_pkg::DATA_W;
  localparam int unsigned SW = gdsa_pkg::SUM_W;
  localparam int unsigned LW = gdsa_pkg::LEN_W;
  localparam int unsigned PW = gdsa_pkg::PROD_W;
  localparam int unsigned RW = gdsa_pkg::SREM_W;
  localparam int unsigned TW = gdsa_pkg::STEP_W;
  localparam int unsigned CW = gdsa_pkg::DIV_CNT_W;
  localparam int unsigned AW = gdsa_pkg::SLOT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // control state
  logic [2:0]    state_q, state_d;
  logic [TW-1:0] step_q, step_d;
  logic [DW-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [LW-1:0] len_q, len_d;
  gdsa_pkg::sum_t sum_q [2];
  gdsa_pkg::sum_t sum_d [2];
  logic [LW-1:0] fill_q, fill_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] div_cnt_q, div_cnt_d;
  logic          out_valid_q, out_valid_d;

  // datapath registers, lane 0 is x / linear, lane 1 is y / angular
  logic [DW:0]          diff_q [2];
  logic [DW:0]          diff_d [2];
  gdsa_pkg::word_t      vel_q [2];
  gdsa_pkg::word_t      vel_d [2];
  gdsa_pkg::word_t      mc_q [2];
  gdsa_pkg::word_t      mc_d [2];
  logic [PW-1:0]        prod_q [2];
  logic [PW-1:0]        prod_d [2];
  logic [PW-1:0]        rad_q, rad_d;
  logic [RW-1:0]        srem_q, srem_d;
  gdsa_pkg::word_t      root_q, root_d;
  logic                 sat_q, sat_d;
  logic [LW+SW-1:0]     dq_q [2];
  logic [LW+SW-1:0]     dq_d [2];
  logic                 neg_q [2];
  logic                 neg_d [2];
  gdsa_pkg::word_t      dist_q, dist_d;
  gdsa_pkg::word_t      avg_q [2];
  gdsa_pkg::word_t      avg_d [2];

  logic          in_xfer, cfg_xfer, full, out_free, out_load, div_start;
  logic [AW-1:0] slot_eff, slot_next;
  logic [LW-1:0] slot_inc;
  logic [2*DW-1:0] ram_rdata;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign full        = (fill_q >= len_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_DONE) && out_free && (div_cnt_q == '0);
  assign div_start   = (state_q == ST_MUL) && (step_q == '1);

  assign slot_eff  = (LW'(slot_q) >= len_q) ? '0 : slot_q;
  assign slot_inc  = LW'(slot_eff) + LW'(1);
  assign slot_next = (slot_inc >= len_q) ? '0 : slot_inc[AW-1:0];

  // history ring, linear sample in the upper half
  gdsa_ram #(
    .WIDTH (2 * DW),
    .DEPTH (gdsa_pkg::WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_LOAD),
    .waddr_i (slot_eff),
    .wdata_i ({vel_q[0], vel_q[1]}),
    .re_i    (in_xfer),
    .raddr_i (slot_eff),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [DW:0]      mag;
    logic [DW:0]      acc;
    logic [SW-1:0]    smag;
    logic [SW-1:0]    old_ext;
    logic [LW:0]      dtrial;
    logic             dge;
    logic [RW+1:0]    st;
    logic [RW+1:0]    strial;
    logic             sge;
    logic [PW:0]      sq_sum;
    gdsa_pkg::word_t  old_s [2];
    logic [CW-1:0]    cfg_w;
    logic [DW-1:0]    wfield;

    mag         = '0;
    acc         = '0;
    smag        = '0;
    old_ext     = '0;
    dtrial      = '0;
    dge         = 1'b0;
    st          = '0;
    strial      = '0;
    sge         = 1'b0;
    sq_sum      = '0;
    state_d     = state_q;
    step_d      = step_q;
    goal_x_d    = goal_x_q;
    goal_y_d    = goal_y_q;
    len_d       = len_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    div_cnt_d   = div_cnt_q;
    rad_d       = rad_q;
    srem_d      = srem_q;
    root_d      = root_q;
    sat_d       = sat_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q;
    old_s[0]    = ram_rdata[2*DW-1:DW];
    old_s[1]    = ram_rdata[DW-1:0];
    cfg_w       = '0;
    wfield      = {{(DW-gdsa_pkg::CFG_LEN_W){1'b0}}, cfg_data_i[gdsa_pkg::CFG_LEN_W-1:0]};

    for (int i = 0; i < 2; i++) begin
      sum_d[i]  = sum_q[i];
      diff_d[i] = diff_q[i];
      vel_d[i]  = vel_q[i];
      mc_d[i]   = mc_q[i];
      prod_d[i] = prod_q[i];
      dq_d[i]   = dq_q[i];
      neg_d[i]  = neg_q[i];
      avg_d[i]  = avg_q[i];
    end

    // configuration writes arrive only while idle
    if (cfg_xfer) begin
      case (cfg_index_i)
        gdsa_pkg::CFG_GOAL_X: begin
          goal_x_d = cfg_data_i;
        end
        gdsa_pkg::CFG_GOAL_Y: begin
          goal_y_d = cfg_data_i;
        end
        gdsa_pkg::CFG_WINDOW_LEN: begin
          if (wfield == '0) begin
            len_d = LW'(1);
          end else if (wfield > DW'(gdsa_pkg::WINDOW_MAX)) begin
            len_d = LW'(gdsa_pkg::WINDOW_MAX);
          end else begin
            len_d = wfield[LW-1:0];
          end
          sum_d[0] = '0;
          sum_d[1] = '0;
          fill_d   = '0;
          slot_d   = '0;
        end
        default: begin
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          diff_d[0] = {pos_x_i[DW-1], pos_x_i} - {goal_x_q[DW-1], goal_x_q};
          diff_d[1] = {pos_y_i[DW-1], pos_y_i} - {goal_y_q[DW-1], goal_y_q};
          vel_d[0]  = lin_vel_i;
          vel_d[1]  = ang_vel_i;
          state_d   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 2; i++) begin
          mag       = diff_q[i][DW] ? (~diff_q[i] + (DW+1)'(1)) : diff_q[i];
          mc_d[i]   = mag[DW-1:0];
          prod_d[i] = {{DW{1'b0}}, mag[DW-1:0]};
          old_ext   = full ? {{(SW-DW){old_s[i][DW-1]}}, old_s[i]} : '0;
          sum_d[i]  = sum_q[i] - old_ext + {{(SW-DW){vel_q[i][DW-1]}}, vel_q[i]};
        end
        if (!full) begin
          fill_d = fill_q + LW'(1);
        end
        slot_d  = slot_next;
        step_d  = '1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // shift-add, one multiplier bit per cycle
        for (int i = 0; i < 2; i++) begin
          acc       = {1'b0, prod_q[i][PW-1:DW]} + (prod_q[i][0] ? {1'b0, mc_q[i]} : '0);
          prod_d[i] = {acc, prod_q[i][DW-1:1]};
        end
        if (step_q == '0) begin
          state_d = ST_ADD;
        end else begin
          step_d = step_q - TW'(1);
        end
      end
      ST_ADD: begin
        sq_sum  = {1'b0, prod_q[0]} + {1'b0, prod_q[1]};
        sat_d   = sq_sum[PW];
        rad_d   = sq_sum[PW-1:0];
        srem_d  = '0;
        root_d  = '0;
        step_d  = '1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        // restoring root, two radicand bits in and one root bit out per cycle
        st     = {srem_q, rad_q[PW-1:PW-2]};
        strial = {2'b00, root_q, 2'b01};
        sge    = (st >= strial);
        srem_d = sge ? RW'(st - strial) : st[RW-1:0];
        root_d = {root_q[DW-2:0], sge};
        rad_d  = {rad_q[PW-3:0], 2'b00};
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - TW'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          dist_d = sat_q ? '1 : root_q;
          for (int i = 0; i < 2; i++) begin
            avg_d[i] = neg_q[i] ? (~dq_q[i][DW-1:0] + DW'(1)) : dq_q[i][DW-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // dividers for the averages run beside the squares and the root
    if (div_start) begin
      for (int i = 0; i < 2; i++) begin
        neg_d[i] = sum_q[i][SW-1];
        smag     = sum_q[i][SW-1] ? (~sum_q[i] + SW'(1)) : sum_q[i];
        dq_d[i]  = {{LW{1'b0}}, smag};
      end
      div_cnt_d = CW'(SW);
    end else if (div_cnt_q != '0) begin
      for (int i = 0; i < 2; i++) begin
        dtrial  = {dq_q[i][LW+SW-1:SW], dq_q[i][SW-1]};
        dge     = (dtrial >= {1'b0, len_q});
        dtrial  = dge ? (dtrial - {1'b0, len_q}) : dtrial;
        dq_d[i] = {dtrial[LW-1:0], dq_q[i][SW-2:0], dge};
      end
      div_cnt_d = div_cnt_q - CW'(1);
    end
    cfg_w = div_cnt_d;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    div_cnt_d = cfg_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      len_q       <= LW'(1);
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      len_q       <= len_d;
      sum_q[0]    <= sum_d[0];
      sum_q[1]    <= sum_d[1];
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    sat_q  <= sat_d;
    dist_q <= dist_d;
    for (int i = 0; i < 2; i++) begin
      diff_q[i] <= diff_d[i];
      vel_q[i]  <= vel_d[i];
      mc_q[i]   <= mc_d[i];
      prod_q[i] <= prod_d[i];
      dq_q[i]   <= dq_d[i];
      neg_q[i]  <= neg_d[i];
      avg_q[i]  <= avg_d[i];
    end
  end

  assign out_valid_o = out_valid_q;
  assign goal_dist_o = dist_q;
  assign lin_avg_o   = avg_q[0];
  assign ang_avg_o   = avg_q[1];

  `ASSERT_NEVER(fill_over_len_a, fill_q > len_q)
  `ASSERT_NEVER(slot_past_len_a, LW'(slot_q) >= len_q)
  `ASSERT_NEVER(len_range_a, (len_q == '0) || (len_q > LW'(gdsa_pkg::WINDOW_MAX)))
  `ASSERT_HOLDS(div_done_before_out_a, (state_q == ST_DONE) |-> (div_cnt_q == '0))
  `ASSERT_HOLDS(root_start_clean_a, (state_q == ST_ADD) |=> ((state_q == ST_SQRT) && (root_q == '0)))

endmodule

`default_nettype wire
